### src/kvi_pkg.sv
// Shared types and constants of the keyframe vector interpolator.
// Used by kvi_ctrl, kvi_dp and keyframe_vector_interpolator; no dependencies.
`default_nettype none

package kvi_pkg;

    localparam int MAX_KEYS   = 64;
    localparam int KEY_W      = $clog2(MAX_KEYS);
    localparam int CNT_W      = KEY_W + 1;
    localparam int TIME_W     = 32;
    localparam int VEC_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 168;
    localparam int M_TDATA_W  = 104;
    localparam int DVD_W      = 48;
    localparam int DIV_CNT_W  = 6;
    localparam int FACT_W     = 31;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_DURATION = 2'd1;

    localparam logic [DVD_W-1:0] FACTOR_LIMIT = 48'd536870912;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_ONE, S_RDN, S_CHK, S_SCAN_ADDR, S_SCAN_CMP,
        S_RDSEG, S_RDNXT, S_LEN, S_DIV, S_FACT, S_MUL, S_ACC, S_OUT
    } kvi_state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_ONE, OP_CAPT0, OP_CHK, OP_SEGZ, OP_SCAN, OP_SEG,
        OP_CAPSEG, OP_LEN, OP_DIV, OP_FACT, OP_MUL, OP_ACC, OP_PUSH
    } kvi_op_t;

    typedef enum logic [2:0] {
        A_ZERO, A_LAST, A_IDX1, A_SEG, A_NXT
    } kvi_addr_t;

    typedef struct packed {
        kvi_op_t   op;
        kvi_addr_t addr_sel;
    } kvi_cmd_t;

    typedef struct packed {
        logic in_sample;
        logic n_one;
        logic chk_found;
        logic scan_end;
        logic scan_hit;
        logic len_empty;
        logic div_last;
        logic last_comp;
        logic out_free;
    } kvi_status_t;

endpackage

`default_nettype wire

### src/kvi_ctrl.sv
// Controller of the keyframe vector interpolator: sequences search, divide and blend.
// Depends on kvi_pkg; drives kvi_dp through a command struct.
`default_nettype none

module kvi_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire kvi_pkg::kvi_status_t st,
    output kvi_pkg::kvi_cmd_t         cmd
);
    import kvi_pkg::*;

    kvi_state_t state_reg;
    kvi_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_tvalid && st.in_sample) state_next = S_RD0;
            S_RD0:       state_next = st.n_one ? S_ONE : S_RDN;
            S_ONE:       state_next = S_OUT;
            S_RDN:       state_next = S_CHK;
            S_CHK:       state_next = st.chk_found ? S_RDSEG : S_SCAN_ADDR;
            S_SCAN_ADDR: state_next = st.scan_end ? S_RDSEG : S_SCAN_CMP;
            S_SCAN_CMP:  state_next = st.scan_hit ? S_RDSEG : S_SCAN_ADDR;
            S_RDSEG:     state_next = S_RDNXT;
            S_RDNXT:     state_next = S_LEN;
            S_LEN:       state_next = st.len_empty ? S_MUL : S_DIV;
            S_DIV:       if (st.div_last) state_next = S_FACT;
            S_FACT:      state_next = S_MUL;
            S_MUL:       state_next = S_ACC;
            S_ACC:       state_next = st.last_comp ? S_OUT : S_MUL;
            S_OUT:       if (st.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op       = OP_NONE;
        cmd.addr_sel = A_ZERO;
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = OP_LOAD;
            end
            S_RD0:       cmd.addr_sel = A_ZERO;
            S_ONE:       cmd.op = OP_ONE;
            S_RDN:
            begin
                cmd.op       = OP_CAPT0;
                cmd.addr_sel = A_LAST;
            end
            S_CHK:       cmd.op = OP_CHK;
            S_SCAN_ADDR:
            begin
                cmd.addr_sel = A_IDX1;
                if (st.scan_end) cmd.op = OP_SEGZ;
            end
            S_SCAN_CMP:  cmd.op = OP_SCAN;
            S_RDSEG:
            begin
                cmd.op       = OP_SEG;
                cmd.addr_sel = A_SEG;
            end
            S_RDNXT:
            begin
                cmd.op       = OP_CAPSEG;
                cmd.addr_sel = A_NXT;
            end
            S_LEN:       cmd.op = OP_LEN;
            S_DIV:       cmd.op = OP_DIV;
            S_FACT:      cmd.op = OP_FACT;
            S_MUL:       cmd.op = OP_MUL;
            S_ACC:       cmd.op = OP_ACC;
            S_OUT:       if (st.out_free) cmd.op = OP_PUSH;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

### src/kvi_dp.sv
// Datapath of the keyframe vector interpolator: key memories, registers,
// serial divider, blend multiplier and output register. Depends on kvi_pkg.
`default_nettype none

module kvi_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire kvi_pkg::kvi_cmd_t                   cmd,
    output kvi_pkg::kvi_status_t                     st,
    input  wire logic [kvi_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [kvi_pkg::M_TDATA_W-1:0]            m_tdata,
    input  wire logic                                cfg_valid,
    input  wire logic [kvi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [kvi_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import kvi_pkg::*;

    logic [TIME_W-1:0]  time_mem [MAX_KEYS];
    logic [3*VEC_W-1:0] vec_mem  [MAX_KEYS];
    logic [TIME_W-1:0]  rd_time_reg;
    logic [3*VEC_W-1:0] rd_vec_reg;

    logic [CNT_W-1:0]   key_count_reg;
    logic [TIME_W-1:0]  duration_reg;
    logic [KEY_W-1:0]   last_seg_reg;
    logic [TIME_W-1:0]  prev_time_reg;
    logic [TIME_W-1:0]  t_reg;
    logic [TIME_W-1:0]  t0_reg;
    logic [KEY_W-1:0]   seg_reg;
    logic [KEY_W-1:0]   idx_reg;
    logic [TIME_W-1:0]  ts_reg;
    logic [3*VEC_W-1:0] vs_reg;
    logic [3*VEC_W-1:0] vn_reg;
    logic [TIME_W-1:0]  rem_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [TIME_W-1:0]  divisor_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic               neg_reg;
    logic signed [FACT_W-1:0] factor_reg;
    logic signed [63:0] prod_reg;
    logic [1:0]         comp_reg;
    logic [3*VEC_W-1:0] res_reg;
    logic               m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [CNT_W-1:0]   n_eff;
    logic [KEY_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   seg_p1;
    logic [KEY_W-1:0]   nxt;
    logic               wr_en;
    logic [KEY_W-1:0]   in_index;
    logic signed [33:0] len_raw;
    logic signed [33:0] len;
    logic signed [32:0] num;
    logic [TIME_W-1:0]  num_mag;
    logic [33:0]        trial;
    logic [DVD_W-1:0]   q_clamp;
    logic signed [32:0] diff;
    logic signed [63:0] prod_next;
    logic signed [63:0] prod_adj;
    logic signed [48:0] sum;
    logic [VEC_W-1:0]   sat_val;
    logic signed [VEC_W-1:0] vs_c;
    logic signed [VEC_W-1:0] vn_c;

    // Key count is clamped into 1..MAX_KEYS.
    always_comb
    begin
        if (key_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (key_count_reg > CNT_W'(MAX_KEYS))
            n_eff = CNT_W'(MAX_KEYS);
        else
            n_eff = key_count_reg;
    end

    assign seg_p1   = {1'b0, seg_reg} + CNT_W'(1);
    assign nxt      = (seg_p1 < n_eff) ? seg_p1[KEY_W-1:0] : '0;
    assign in_index = s_tdata[KEY_W-1:0];
    assign wr_en    = (cmd.op == OP_LOAD) && !s_tuser;

    always_comb
    begin
        case (cmd.addr_sel)
            A_ZERO:  rd_addr = '0;
            A_LAST:  rd_addr = KEY_W'(n_eff - CNT_W'(1));
            A_IDX1:  rd_addr = idx_reg + KEY_W'(1);
            A_SEG:   rd_addr = seg_reg;
            A_NXT:   rd_addr = nxt;
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[in_index] <= s_tdata[KEY_W +: TIME_W];
            vec_mem[in_index]  <= s_tdata[KEY_W+TIME_W +: 3*VEC_W];
        end
        rd_time_reg <= time_mem[rd_addr];
        rd_vec_reg  <= vec_mem[rd_addr];
    end

    // Segment length with the wrap correction, and offset into the segment.
    assign len_raw = $signed({2'b00, rd_time_reg}) - $signed({2'b00, ts_reg});
    assign len     = len_raw[33] ? len_raw + $signed({2'b00, duration_reg}) : len_raw;
    assign num     = $signed({1'b0, t_reg}) - $signed({1'b0, ts_reg});
    assign num_mag = num[32] ? TIME_W'(-num) : num[TIME_W-1:0];

    assign trial   = {1'b0, rem_reg, dvd_reg[DVD_W-1]} - {2'b00, divisor_reg};
    assign q_clamp = (dvd_reg > FACTOR_LIMIT) ? FACTOR_LIMIT : dvd_reg;

    assign vs_c      = $signed(vs_reg[comp_reg*VEC_W +: VEC_W]);
    assign vn_c      = $signed(vn_reg[comp_reg*VEC_W +: VEC_W]);
    assign diff      = 33'(vn_c) - 33'(vs_c);
    assign prod_next = factor_reg * diff;
    // Division by 65536 truncating toward zero.
    assign prod_adj  = prod_reg[63] ? prod_reg + 64'sd65535 : prod_reg;
    assign sum       = 49'(vs_c) + 49'($signed(prod_adj[63:16]));

    always_comb
    begin
        if (sum > 49'sd2147483647)
            sat_val = 32'h7FFF_FFFF;
        else if (sum < -49'sd2147483648)
            sat_val = 32'h8000_0000;
        else
            sat_val = sum[VEC_W-1:0];
    end

    always_comb
    begin
        st.in_sample = s_tuser;
        st.n_one     = (n_eff == CNT_W'(1));
        st.chk_found = (t_reg < t0_reg) || (t_reg >= rd_time_reg);
        st.scan_end  = ({1'b0, idx_reg} >= (n_eff - CNT_W'(1)));
        st.scan_hit  = (t_reg < rd_time_reg);
        st.len_empty = len[33] || (len == '0);
        st.div_last  = (div_cnt_reg == DIV_CNT_W'(1));
        st.last_comp = (comp_reg == 2'd2);
        st.out_free  = !m_valid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= CNT_W'(1);
            duration_reg  <= 32'd65536;
            last_seg_reg  <= '0;
            prev_time_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_KEY_COUNT)
                    key_count_reg <= cfg_data[CNT_W-1:0];
                else if (cfg_index == REG_TRACK_DURATION)
                    duration_reg <= cfg_data[TIME_W-1:0];
            end
            if (cmd.op == OP_SEG)
                last_seg_reg <= seg_reg;
            if (cmd.op == OP_PUSH)
            begin
                prev_time_reg <= t_reg;
                m_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:   t_reg <= s_tdata[KEY_W+TIME_W+3*VEC_W +: TIME_W];
            OP_ONE:
            begin
                res_reg <= rd_vec_reg;
                seg_reg <= '0;
            end
            OP_CAPT0:  t0_reg <= rd_time_reg;
            OP_CHK:
            begin
                if (t_reg < t0_reg)
                    seg_reg <= '0;
                else if (t_reg >= rd_time_reg)
                    seg_reg <= KEY_W'(n_eff - CNT_W'(1));
                else
                    idx_reg <= (t_reg >= prev_time_reg) ? last_seg_reg : '0;
            end
            OP_SEGZ:   seg_reg <= '0;
            OP_SCAN:
            begin
                if (t_reg < rd_time_reg)
                    seg_reg <= idx_reg;
                else
                    idx_reg <= idx_reg + KEY_W'(1);
            end
            OP_CAPSEG:
            begin
                ts_reg <= rd_time_reg;
                vs_reg <= rd_vec_reg;
            end
            OP_LEN:
            begin
                vn_reg      <= rd_vec_reg;
                neg_reg     <= num[32];
                dvd_reg     <= {num_mag, 16'd0};
                rem_reg     <= '0;
                divisor_reg <= len[TIME_W-1:0];
                div_cnt_reg <= DIV_CNT_W'(DVD_W);
                factor_reg  <= '0;
                comp_reg    <= '0;
            end
            OP_DIV:
            begin
                div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
                if (!trial[33])
                begin
                    rem_reg <= trial[TIME_W-1:0];
                    dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[TIME_W-2:0], dvd_reg[DVD_W-1]};
                    dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                end
            end
            OP_FACT:
            begin
                factor_reg <= neg_reg ? -$signed(q_clamp[FACT_W-1:0])
                                      : $signed(q_clamp[FACT_W-1:0]);
            end
            OP_MUL:    prod_reg <= prod_next;
            OP_ACC:
            begin
                res_reg[comp_reg*VEC_W +: VEC_W] <= sat_val;
                comp_reg <= comp_reg + 2'd1;
            end
            OP_PUSH:   m_data_reg <= {2'b00, seg_reg, res_reg};
            default:   ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_DIV |-> div_cnt_reg != '0)
        else $error("divider stepped with no bits left");

    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LEN |-> {1'b0, seg_reg} < n_eff)
        else $error("chosen segment beyond key count");

    a_factor_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_MUL |-> (factor_reg <= 31'sd536870912) &&
                             (factor_reg >= -31'sd536870912))
        else $error("blend factor outside clamp");

    a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_PUSH |=> m_valid_reg)
        else $error("result not presented after push");

endmodule

`default_nettype wire

### src/keyframe_vector_interpolator.sv
// A key write goes into the key memory when it is accepted in the idle state. A sample
// on a single-key track returns that key's vector; else the bound check, a key scan if needed,
// the serial divider and the blend run in turn; the divider is skipped for a zero or negative length.
// Throughput: one sample at a time; the next item is taken the cycle after the result
// is registered, and a result still held by m_tready stalls the input.
// Reset (rst_n low, asynchronous) loads register defaults, clears hint and output valid.
`default_nettype none

module keyframe_vector_interpolator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // key_index, key_time, key_x, key_y, key_z, sample_time, zero pad (LSB first)
    input  wire logic [kvi_pkg::S_TDATA_W-1:0]     s_tdata,
    // command
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_x, out_y, out_z, segment, zero pad (LSB first)
    output logic [kvi_pkg::M_TDATA_W-1:0]          m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [kvi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [kvi_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import kvi_pkg::*;

    kvi_cmd_t    cmd;
    kvi_status_t st;

    assign cfg_ready = 1'b1;

    kvi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    kvi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

### sim/kvi_checker.sv
// Checker of the keyframe vector interpolator: watches the key, sample, result and
// register channels, keeps its own track state and compares every result.
// Depends on kvi_pkg for port widths and register indexes.
`timescale 1ns / 100ps

module kvi_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [kvi_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [kvi_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [kvi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kvi_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                            pending,
    output int                            fail_count
);
    import kvi_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [5:0]  seg;
    } blend_t;

    logic [31:0]        trk_time [MAX_KEYS];
    logic signed [31:0] trk_vec  [MAX_KEYS][3];
    logic [5:0]         hint_seg;
    logic [31:0]        prev_t;
    logic [6:0]         key_count;
    logic [31:0]        duration;
    blend_t             blend_q[$];
    int                 mismatches;

    assign pending    = blend_q.size();
    assign fail_count = mismatches + blend_q.size();

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic blend_t blend_at(logic [31:0] t);
        int     n, seg, nxt, start;
        longint len, num, factor, s, d;
        blend_t r;
        logic signed [31:0] o[3];
        n = key_count;
        if (n < 1) n = 1;
        if (n > MAX_KEYS) n = MAX_KEYS;
        if (n == 1) begin
            r.x = trk_vec[0][0];
            r.y = trk_vec[0][1];
            r.z = trk_vec[0][2];
            r.seg = '0;
            prev_t = t;
            return r;
        end
        if (t < trk_time[0]) seg = 0;
        else if (t >= trk_time[n-1]) seg = n - 1;
        else begin
            start = (t >= prev_t) ? int'(hint_seg) : 0;
            seg = 0;
            for (int i = start; i + 1 < n; i++)
                if (t < trk_time[i+1]) begin
                    seg = i;
                    break;
                end
        end
        hint_seg = seg[5:0];
        nxt = (seg + 1 < n) ? seg + 1 : 0;
        len = longint'(trk_time[nxt]) - longint'(trk_time[seg]);
        if (len < 0) len += longint'(duration);
        num = longint'(t) - longint'(trk_time[seg]);
        if (len <= 0) factor = 0;
        else begin
            factor = (num * 65536) / len;
            if (factor > (64'sd1 << 29)) factor = 64'sd1 << 29;
            if (factor < -(64'sd1 << 29)) factor = -(64'sd1 << 29);
        end
        for (int j = 0; j < 3; j++) begin
            s = trk_vec[seg][j];
            d = longint'(trk_vec[nxt][j]) - s;
            o[j] = sat32(s + (factor * d) / 65536);
        end
        r.x = o[0];
        r.y = o[1];
        r.z = o[2];
        r.seg = seg[5:0];
        prev_t = t;
        return r;
    endfunction

    initial
    begin
        mismatches = 0;
        foreach (trk_time[i])
        begin
            trk_time[i] = '0;
            trk_vec[i][0] = '0;
            trk_vec[i][1] = '0;
            trk_vec[i][2] = '0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        blend_t exp_b, got;
        logic [5:0] k;
        if (!rst_n)
        begin
            hint_seg  = '0;
            prev_t    = '0;
            key_count = 7'd1;
            duration  = 32'd65536;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_KEY_COUNT) key_count = cfg_data[6:0];
                else if (cfg_index == REG_TRACK_DURATION) duration = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                got.x = m_tdata[31:0];
                got.y = m_tdata[63:32];
                got.z = m_tdata[95:64];
                got.seg = m_tdata[101:96];
                if (blend_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction %h", $time, got);
                    mismatches++;
                end
                else
                begin
                    exp_b = blend_q.pop_front();
                    if (got.x !== exp_b.x || got.y !== exp_b.y || got.z !== exp_b.z
                        || got.seg !== exp_b.seg)
                    begin
                        $display("%0t: mismatch expected x=%h y=%h z=%h seg=%0d",
                                 $time, exp_b.x, exp_b.y, exp_b.z, exp_b.seg);
                        $display("%0t:          actual   x=%h y=%h z=%h seg=%0d",
                                 $time, got.x, got.y, got.z, got.seg);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                    blend_q = {blend_q, blend_at(s_tdata[165:134])};
                else
                begin
                    k = s_tdata[5:0];
                    trk_time[k]   = s_tdata[37:6];
                    trk_vec[k][0] = s_tdata[69:38];
                    trk_vec[k][1] = s_tdata[101:70];
                    trk_vec[k][2] = s_tdata[133:102];
                end
            end
        end
    end

endmodule

### sim/tb_top.sv
// Top of the interpolator testbench: clock, reset, key and sample stimulus,
// register phases and verdict. Depends on kvi_pkg, kvi_checker and the block.
`timescale 1ns / 100ps

module tb_top;
    import kvi_pkg::*;

    localparam int IDLE_LIMIT  = 30000;
    localparam int DRAIN_WAIT  = 250;
    localparam int HOLD_CYCLES = 4000;
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     pending;
    int                     fail_count;
    int                     idle_cycles = 0;
    int                     burst_left;
    logic [31:0]            key_t [MAX_KEYS];
    logic [31:0]            sweep_t;

    keyframe_vector_interpolator DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    kvi_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .fail_count(fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Any transaction on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, then changing patterns.
    initial
    begin
        int mode;
        m_tready = 1'b0;
        @(posedge rst_n);
        repeat (3000) @(posedge clk) m_tready <= ($urandom_range(0, 2) != 0);
        repeat (HOLD_CYCLES) @(posedge clk) m_tready <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(50, 2000)) @(posedge clk)
            begin
                if (mode == 0) m_tready <= 1'b1;
                else if (mode == 1) m_tready <= ($urandom_range(0, 3) == 0);
                else m_tready <= $urandom_range(0, 1);
            end
        end
    end

    task automatic send_item(logic cmd, logic [5:0] idx, logic [31:0] kt, logic [31:0] kx,
                             logic [31:0] ky, logic [31:0] kz, logic [31:0] st);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, st, kz, ky, kx, kt, idx};
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (cmd == CMD_WRITE) key_t[idx] = kt;
    endtask

    task automatic write_key(logic [5:0] idx, logic [31:0] kt);
        send_item(CMD_WRITE, idx, kt, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic sample_at(logic [31:0] st);
        send_item(CMD_SAMPLE, 6'($urandom), $urandom, $urandom, $urandom, $urandom, st);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Loads an ascending track; a zero step now and then makes empty segments.
    task automatic load_track(logic [31:0] step_max);
        logic [31:0] t;
        t = $urandom_range(0, 32'h3FFF_FFFF);
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            write_key(6'(i), t);
            if ($urandom_range(0, 9) != 0) t = t + $urandom_range(1, step_max);
        end
    endtask

    task automatic random_items(int count, int n_keys);
        logic [31:0] first, last;
        int k, r;
        for (int i = 0; i < count; i++)
        begin
            first = key_t[0];
            last  = key_t[(n_keys < 1) ? 0 : (n_keys > 64 ? 63 : n_keys - 1)];
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                // Fresh vector at a key, keeping its time.
                k = $urandom_range(0, 63);
                write_key(6'(k), key_t[k]);
            end
            else if (r < 24)
                write_key(6'($urandom), $urandom);
            else if (r < 75)
            begin
                sweep_t = sweep_t + $urandom_range(0, 32'h0400_0000);
                if (sweep_t > last + 32'h0200_0000 || sweep_t < first - 32'h0100_0000)
                    sweep_t = first - $urandom_range(0, 32'h0080_0000);
                sample_at(sweep_t);
            end
            else if (r < 85)
            begin
                sweep_t = $urandom_range(first, last);
                sample_at(sweep_t);
            end
            else if (r < 90)
                sample_at(key_t[$urandom_range(0, 63)]);
            else
                sample_at($urandom);
        end
    endtask

    initial
    begin
        logic [31:0] ext [4];
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_WRITE;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        burst_left = 0;
        sweep_t    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: a single key returns its own vector.
        send_item(CMD_WRITE, 6'd0, 32'd100, ext[0], ext[1], ext[2], 32'd0);
        sample_at(32'd0);
        sample_at(32'hFFFF_FFFF);
        settle();

        // Directed extremes on a two-key track with a long duration.
        write_reg(REG_KEY_COUNT, 32'd2);
        write_reg(REG_TRACK_DURATION, 32'hFFFF_FFFF);
        send_item(CMD_WRITE, 6'd0, 32'h0001_0000, ext[0], ext[1], ext[3], 32'd0);
        send_item(CMD_WRITE, 6'd1, 32'h0002_0000, ext[1], ext[0], ext[2], 32'd0);
        send_item(CMD_WRITE, 6'd63, 32'hFFFF_FFFF, ext[1], ext[1], ext[0], 32'd0);
        sample_at(32'd0);
        sample_at(32'h0001_8000);
        sample_at(32'h0002_0000);
        sample_at(32'hFFFF_FFFF);
        sample_at(32'h0001_0000);
        sample_at(32'h0000_8000);
        settle();
        // Saturation: a short segment sampled far before its start.
        write_reg(REG_TRACK_DURATION, 32'd1);
        send_item(CMD_WRITE, 6'd1, 32'h0001_0001, ext[0], ext[1], ext[0], 32'd0);
        sample_at(32'h0001_0000);
        sample_at(32'h0000_0000);
        sample_at(32'h0001_0001);
        sample_at(32'h8000_0000);
        settle();
        // Unknown register indexes are ignored.
        write_reg(2'd2, $urandom);
        write_reg(2'd3, $urandom);

        load_track(32'h0020_0000);
        sweep_t = key_t[0];

        for (int phase = 0; phase < 7; phase++)
        begin
            int n_keys;
            logic [31:0] dur;
            case (phase)
                0: n_keys = 64;
                1: n_keys = 2;
                2: n_keys = 0;
                3: n_keys = 100;
                4: n_keys = 127;
                default: n_keys = $urandom_range(3, 63);
            endcase
            case (phase)
                0: dur = 32'hFFFF_FFFF;
                1: dur = 32'd1;
                2: dur = 32'd65536;
                default: dur = $urandom_range(1, 32'h1000_0000);
            endcase
            settle();
            write_reg(REG_KEY_COUNT, 32'(n_keys[6:0]));
            write_reg(REG_TRACK_DURATION, dur);
            if (phase == 3) load_track(32'h0100_0000);
            if (phase == 5) load_track(32'h0000_0100);
            sweep_t = key_t[0] - 32'h0010_0000;
            random_items(90, n_keys);
        end

        settle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
src/kvi_pkg.sv
src/kvi_ctrl.sv
src/kvi_dp.sv
src/keyframe_vector_interpolator.sv
sim/kvi_checker.sv
sim/tb_top.sv
